// File: hw/rtl/task_paged_mmu_local_decode_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the task-paged memory unit
// Checks are clocked on clk_i and held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TASK_PAGED_MMU_LOCAL_DECODE_ASSERT_SVH
`define TASK_PAGED_MMU_LOCAL_DECODE_ASSERT_SVH

`ifndef SYNTH
`define TMU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define TMU_ASSERT_NEVER(name, cond, msg) \
  `TMU_ASSERT(name, !(cond), msg)
`else
`define TMU_ASSERT(name, prop, msg)
`define TMU_ASSERT_NEVER(name, cond, msg)
`endif

`endif

// File: hw/rtl/tmu_pkg.sv
// ----------------------------------------------------------------------------
// tmu_pkg
// Types and constants shared by the task-paged memory unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tmu_pkg;

  localparam int unsigned MAP_BYTES       = 512;
  localparam int unsigned LOCAL_RAM_BYTES = 1024;

  localparam logic [7:0]  SWITCH_RESET = 8'd250;
  localparam logic [7:0]  SWITCH_MASK  = 8'hFC;

  // local window map (task 0)
  localparam logic [15:0] LOC_TOP       = 16'h1000;
  localparam logic [15:0] LOC_CTRL_BASE = 16'h0400;
  localparam logic [15:0] LOC_SW_TASK   = 16'h0402;
  localparam logic [15:0] LOC_MASK      = 16'h0403;
  localparam logic [15:0] LOC_MAP_BASE  = 16'h0600;
  localparam logic [15:0] LOC_MAP_END   = 16'h07FF;
  localparam logic [15:0] LOC_ROM_END   = 16'h0BFF;
  localparam logic [15:0] BOOT_END      = 16'h000F;
  localparam logic [9:0]  BOOT_ROM_BASE = 10'h3F0;
  localparam logic [15:0] IO_ECHO_MASK  = 16'hFF00;

  typedef enum logic [2:0] {
    REQ_MEM_RD = 3'd0,
    REQ_MEM_WR = 3'd1,
    REQ_IO_RD  = 3'd2,
    REQ_IO_WR  = 3'd3,
    REQ_IRQ    = 3'd4,
    REQ_NMI    = 3'd5
  } tmu_req_e;

  typedef enum logic [2:0] {
    TGT_LOCAL  = 3'd0,
    TGT_BUS_RD = 3'd1,
    TGT_BUS_WR = 3'd2,
    TGT_ROM_RD = 3'd3,
    TGT_IO_RD  = 3'd4,
    TGT_IO_WR  = 3'd5
  } tmu_target_e;

  // decoded access, waiting on the memory read data
  typedef struct packed {
    tmu_target_e target;
    logic [23:0] addr;     // frame bits 19..12 are filled from the map when use_map
    logic [7:0]  wdata;
    logic [7:0]  rdata;    // replaced by local RAM data when use_ram
    logic        use_map;
    logic        use_ram;
    logic        irq;
    logic        nmi;
  } tmu_dec_t;

  // memory requests raised by one access
  typedef struct packed {
    logic        ram_we;
    logic        map_we;
    logic [15:0] ram_addr;
    logic [8:0]  map_ridx;
    logic [15:0] map_widx;
    logic [7:0]  wdata;
  } tmu_mem_t;

endpackage

`default_nettype wire

// File: hw/rtl/tmu_ram.sv
// ----------------------------------------------------------------------------
// tmu_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/tmu_ctrl.sv
// ----------------------------------------------------------------------------
// tmu_ctrl
// Control registers and access decode: task/mask/switch state, interrupt
// lines, local window decode and memory requests for one accepted word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tmu_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [7:0]          cfg_wdata_i,
  input  wire logic                accept_i,
  input  wire logic [2:0]          req_i,
  input  wire logic [15:0]         addr_i,
  input  wire logic [7:0]          wdata_i,
  input  wire logic                level_i,
  output tmu_pkg::tmu_dec_t        dec_o,
  output tmu_pkg::tmu_mem_t        mem_o
);
  import tmu_pkg::*;

  logic [7:0] sw_q, task_q, task_d, mask_q, mask_d;
  logic       trap_q, trap_d, boot_q;
  logic       pint_n_q, pint_n_d, nmi_n_q, nmi_n_d;
  logic       irq_q, irq_d, nmi_q, nmi_d;

  logic       task0, local_acc, en, pend;
  tmu_req_e   req;

  assign req       = tmu_req_e'(req_i);
  assign task0     = (task_q[3:0] == 4'd0);
  assign local_acc = task0 && (addr_i < LOC_TOP);
  assign en        = task0 ? mask_q[5] : !mask_q[2];
  assign pend      = !(nmi_n_q && pint_n_q);

  always_comb begin
    dec_o          = '0;
    dec_o.target   = TGT_LOCAL;
    dec_o.irq      = irq_q;
    dec_o.nmi      = nmi_q;
    mem_o          = '0;
    mem_o.ram_addr = addr_i;
    mem_o.map_ridx = {task_q[3:0], addr_i[15:12], 1'b0};
    mem_o.map_widx = addr_i - LOC_MAP_BASE;
    mem_o.wdata    = wdata_i;
    task_d         = task_q;
    mask_d         = mask_q;
    trap_d         = trap_q;
    pint_n_d       = pint_n_q;
    nmi_n_d        = nmi_n_q;
    irq_d          = irq_q;
    nmi_d          = nmi_q;

    case (req)
      REQ_MEM_RD: begin
        if (boot_q && (addr_i <= BOOT_END)) begin
          dec_o.target = TGT_ROM_RD;
          dec_o.addr   = {13'd0, trap_q, BOOT_ROM_BASE | {6'd0, addr_i[3:0]}};
        end else if (!local_acc) begin
          dec_o.target  = TGT_BUS_RD;
          dec_o.addr    = {task_q[7:4], 8'd0, addr_i[11:0]};
          dec_o.use_map = 1'b1;
        end else if (addr_i < LOC_CTRL_BASE) begin
          dec_o.use_ram = 1'b1;
        end else if (addr_i == LOC_SW_TASK) begin
          dec_o.rdata = (sw_q & SWITCH_MASK) | {6'd0, pend, trap_q};
        end else if (addr_i inside {[LOC_CTRL_BASE:LOC_MASK], [LOC_MAP_BASE:LOC_MAP_END]}) begin
          dec_o.rdata = '0;
        end else if (addr_i <= LOC_ROM_END) begin
          dec_o.target = TGT_ROM_RD;
          dec_o.addr   = {13'd0, trap_q, addr_i[9:0]};
        end
      end
      REQ_MEM_WR: begin
        if (!local_acc) begin
          dec_o.target  = TGT_BUS_WR;
          dec_o.addr    = {task_q[7:4], 8'd0, addr_i[11:0]};
          dec_o.use_map = 1'b1;
          dec_o.wdata   = wdata_i;
        end else if (addr_i < LOC_CTRL_BASE) begin
          mem_o.ram_we = 1'b1;
        end else if (addr_i == LOC_SW_TASK) begin
          task_d = wdata_i;
          trap_d = 1'b1;
        end else if (addr_i == LOC_MASK) begin
          mask_d = wdata_i;
        end else if (addr_i inside {[LOC_MAP_BASE:LOC_MAP_END]}) begin
          mem_o.map_we = 1'b1;
        end
      end
      REQ_IO_RD, REQ_IO_WR: begin
        // port echoed into the upper byte when mask bit 7 is set
        if (mask_q[7]) begin
          dec_o.addr = {8'd0, ({addr_i[7:0], 8'd0} & IO_ECHO_MASK) | {8'd0, addr_i[7:0]}};
        end else begin
          dec_o.addr = {8'd0, addr_i};
        end
        if (req == REQ_IO_RD) begin
          dec_o.target = TGT_IO_RD;
        end else begin
          dec_o.target = TGT_IO_WR;
          dec_o.wdata  = wdata_i;
        end
      end
      REQ_IRQ: begin
        pint_n_d  = !level_i;
        irq_d     = !pint_n_d && en;
        nmi_d     = !nmi_n_q && en;
        dec_o.irq = irq_d;
        dec_o.nmi = nmi_d;
      end
      REQ_NMI: begin
        nmi_n_d   = 1'b0;
        irq_d     = !pint_n_q && en;
        nmi_d     = en;
        dec_o.irq = irq_d;
        dec_o.nmi = nmi_d;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sw_q     <= SWITCH_RESET;
      task_q   <= '0;
      mask_q   <= '0;
      trap_q   <= 1'b0;
      boot_q   <= 1'b1;
      pint_n_q <= 1'b1;
      nmi_n_q  <= 1'b1;
      irq_q    <= 1'b0;
      nmi_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        sw_q <= cfg_wdata_i;
      end
      // overlay stays on: nothing in this unit turns it off
      boot_q <= boot_q;
      if (accept_i) begin
        task_q   <= task_d;
        mask_q   <= mask_d;
        trap_q   <= trap_d;
        pint_n_q <= pint_n_d;
        nmi_n_q  <= nmi_n_d;
        irq_q    <= irq_d;
        nmi_q    <= nmi_d;
      end
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/task_paged_mmu_local_decode.sv
// ----------------------------------------------------------------------------
// task_paged_mmu_local_decode
// Task-paged memory unit: bus address translation and local window decode.
// ----------------------------------------------------------------------------
// Takes one CPU bus access word per clock while the output side is not
// stalled and returns one result word for each via a decode register and
// an output register. The decode stage spans the synchronous read of the
// page map and local RAM, addressed directly from the incoming word;
// register and memory writes land at the accepting edge, so the next word
// always sees them. Memories hold no contents after reset until written.
`timescale 1ns / 1ps
`default_nettype none

`include "task_paged_mmu_local_decode_assert.svh"

module task_paged_mmu_local_decode #(
  parameter int unsigned MapBytes      = tmu_pkg::MAP_BYTES,
  parameter int unsigned LocalRamBytes = tmu_pkg::LOCAL_RAM_BYTES
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [15:0] cpu_address, [23:16] write_data, [24] line_level, [31:25] zero
  input  wire logic [31:0] s_axis_tdata,
  // [2:0] req_type
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [23:0] bus_address, [31:24] bus_write_data, [39:32] read_data,
  // [40] irq_out, [41] nmi_out, [47:42] zero
  output logic [47:0]      m_axis_tdata,
  // [2:0] target
  output logic [2:0]       m_axis_tuser
);
  import tmu_pkg::*;

  localparam int unsigned MapAw = $clog2(MapBytes);
  localparam int unsigned RamAw = $clog2(LocalRamBytes);

  logic     accept, out_free;
  logic     s1_valid_q, s1_valid_d;
  tmu_dec_t s1_q, dec;
  tmu_mem_t mem;
  logic     out_valid_q, out_valid_d;
  logic [47:0] out_data_q, out_data_d;
  logic [2:0]  out_user_q, out_user_d;
  logic [7:0]  map_rdata, ram_rdata;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !s1_valid_q || out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  tmu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_i       (s_axis_tuser),
    .addr_i      (s_axis_tdata[15:0]),
    .wdata_i     (s_axis_tdata[23:16]),
    .level_i     (s_axis_tdata[24]),
    .dec_o       (dec),
    .mem_o       (mem)
  );

  tmu_ram #(
    .Width (8),
    .Depth (MapBytes)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mem.map_we),
    .waddr_i (MapAw'(mem.map_widx)),
    .wdata_i (mem.wdata),
    .re_i    (accept),
    .raddr_i (MapAw'(mem.map_ridx)),
    .rdata_o (map_rdata)
  );

  tmu_ram #(
    .Width (8),
    .Depth (LocalRamBytes)
  ) u_local_ram (
    .clk_i   (clk_i),
    .we_i    (accept && mem.ram_we),
    .waddr_i (RamAw'(mem.ram_addr)),
    .wdata_i (mem.wdata),
    .re_i    (accept),
    .raddr_i (RamAw'(mem.ram_addr)),
    .rdata_o (ram_rdata)
  );

  // RAM read data holds while the decode stage waits, since reads fire on accept only
  always_comb begin
    logic [23:0] addr;
    logic [7:0]  rdata;
    addr  = s1_q.use_map ? {s1_q.addr[23:20], map_rdata, s1_q.addr[11:0]} : s1_q.addr;
    rdata = s1_q.use_ram ? ram_rdata : s1_q.rdata;

    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (out_free) begin
      out_valid_d = s1_valid_q;
      s1_valid_d  = 1'b0;
      out_data_d  = {6'd0, s1_q.nmi, s1_q.irq, rdata, s1_q.wdata, addr};
      out_user_d  = s1_q.target;
    end
    if (accept) begin
      s1_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= dec;
    end
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

  `TMU_ASSERT(a_stall_blocks_in, (s1_valid_q && out_valid_q && !m_axis_tready) |-> !s_axis_tready, "decode stage overrun")
  `TMU_ASSERT(a_accept_fills_s1, accept |=> s1_valid_q, "accepted word lost")
  `TMU_ASSERT_NEVER(a_local_addr_zero, out_valid_q && (out_user_q == TGT_LOCAL) && (out_data_q[23:0] != 24'd0), "local result with address")
  `TMU_ASSERT_NEVER(a_rdata_only_local, out_valid_q && (out_user_q != TGT_LOCAL) && (out_data_q[39:32] != 8'd0), "read data on bus result")

endmodule

`default_nettype wire

// File: verif/task_paged_mmu_local_decode_tb.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// task_paged_mmu_local_decode_tb
// Self-checking bench for the task-paged memory unit. A shadow decoder keeps
// its own copy of the task, mask, interrupt, map and RAM state. It works out
// each result word when the input word is accepted. Stimulus is a directed
// walk through the local window, then random phases under several switch
// settings. The last phase moves to a task outside the local window. Both
// stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module task_paged_mmu_local_decode_tb;
  import tmu_pkg::*;

  localparam logic [2:0] REQ_SPARE_6 = 3'd6;
  localparam logic [2:0] REQ_SPARE_7 = 3'd7;

  localparam logic [1:0] RX_OPEN     = 2'd0;
  localparam logic [1:0] RX_LIGHT    = 2'd1;
  localparam logic [1:0] RX_HEAVY    = 2'd2;
  localparam logic [1:0] RX_PERIODIC = 2'd3;

  localparam int unsigned PHASE_WORDS = 50;

  typedef struct packed {
    logic [2:0]  req;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        level;
  } cpu_access_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [23:0] addr;
    logic [7:0]  wdata;
    logic [7:0]  rdata;
    logic        irq;
    logic        nmi;
  } access_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [15:0] cpu_address, [23:16] write_data, [24] line_level, [31:25] zero
  logic [31:0] s_axis_tdata = '0;
  // [2:0] req_type
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [23:0] bus_address, [31:24] bus_write_data, [39:32] read_data,
  // [40] irq_out, [41] nmi_out, [47:42] zero
  logic [47:0] m_axis_tdata;
  // [2:0] target
  logic [2:0]  m_axis_tuser;

  task_paged_mmu_local_decode dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("task_paged_mmu_local_decode_tb: done, errors");
    $finish;
  end

  cpu_access_t    access_q [$];
  access_result_t result_q [$];
  int unsigned    err_cnt = 0;

  // ---------------------------------------------------------------- shadow
  logic [7:0] switch_byte = SWITCH_RESET;
  logic [7:0] cur_task = '0;
  logic [7:0] cur_mask = '0;
  logic       trap_flag = 1'b0;
  logic       overlay_on = 1'b1;
  logic       pint_n = 1'b1;
  logic       nmi_n = 1'b1;
  logic       irq_state = 1'b0;
  logic       nmi_state = 1'b0;
  logic [7:0] frame_map [MAP_BYTES];
  logic [7:0] ram_img [LOCAL_RAM_BYTES];

  function automatic logic [23:0] paged_address(input logic [15:0] a);
    return {cur_task[7:4], frame_map[{cur_task[3:0], a[15:12], 1'b0}], a[11:0]};
  endfunction

  // only interrupt events recompute the lines, task/mask writes do not
  function automatic void refresh_lines();
    logic en;
    en = (cur_task[3:0] == 4'd0) ? cur_mask[5] : ~cur_mask[2];
    irq_state = ~pint_n & en;
    nmi_state = ~nmi_n & en;
  endfunction

  function automatic access_result_t decode_access(input cpu_access_t w);
    access_result_t r;
    logic in_window;
    r = '0;
    in_window = (cur_task[3:0] == 4'd0) && (w.addr < LOC_TOP);
    case (w.req)
      REQ_MEM_RD: begin
        if (overlay_on && w.addr <= BOOT_END) begin
          r.target = TGT_ROM_RD;
          r.addr = {13'd0, trap_flag, BOOT_ROM_BASE | w.addr[9:0]};
        end else if (!in_window) begin
          r.target = TGT_BUS_RD;
          r.addr = paged_address(w.addr);
        end else if (w.addr < LOC_CTRL_BASE) begin
          r.rdata = ram_img[w.addr[9:0]];
        end else if (w.addr == LOC_SW_TASK) begin
          r.rdata = (switch_byte & SWITCH_MASK) | {6'd0, ~(nmi_n & pint_n), trap_flag};
        end else if ((w.addr > LOC_MASK && w.addr < LOC_MAP_BASE) ||
                     (w.addr > LOC_MAP_END && w.addr <= LOC_ROM_END)) begin
          r.target = TGT_ROM_RD;
          r.addr = {13'd0, trap_flag, w.addr[9:0]};
        end
      end
      REQ_MEM_WR: begin
        if (!in_window) begin
          r.target = TGT_BUS_WR;
          r.addr = paged_address(w.addr);
          r.wdata = w.wdata;
        end else if (w.addr < LOC_CTRL_BASE) begin
          ram_img[w.addr[9:0]] = w.wdata;
        end else if (w.addr == LOC_SW_TASK) begin
          cur_task = w.wdata;
          trap_flag = 1'b1;
        end else if (w.addr == LOC_MASK) begin
          cur_mask = w.wdata;
        end else if (w.addr >= LOC_MAP_BASE && w.addr <= LOC_MAP_END) begin
          frame_map[w.addr[8:0]] = w.wdata;
        end
      end
      REQ_IO_RD, REQ_IO_WR: begin
        r.addr = cur_mask[7] ? {8'd0, w.addr[7:0], w.addr[7:0]} : {8'd0, w.addr};
        if (w.req == REQ_IO_RD) begin
          r.target = TGT_IO_RD;
        end else begin
          r.target = TGT_IO_WR;
          r.wdata = w.wdata;
        end
      end
      REQ_IRQ: begin
        pint_n = ~w.level;
        refresh_lines();
      end
      REQ_NMI: begin
        nmi_n = 1'b0;
        refresh_lines();
      end
      default: ;
    endcase
    r.irq = irq_state;
    r.nmi = nmi_state;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  cpu_access_t drv_word;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(decode_access(drv_word));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left != 0 || access_q.size() == 0) begin
          if (gap_left != 0) gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else begin
          drv_word = access_q.pop_front();
          s_axis_tdata  <= {7'd0, drv_word.level, drv_word.wdata, drv_word.addr};
          s_axis_tuser  <= drv_word.req;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------- monitor
  logic [31:0] rx_cycle = '0;
  logic [1:0]  rx_mode = RX_OPEN;

  task automatic report_field(input string name, input logic [23:0] exp_v,
                              input logic [23:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    err_cnt++;
  endtask

  task automatic check_result(input access_result_t got);
    access_result_t exp_r;
    if (result_q.size() == 0) begin
      $display("%0t: unexpected result word %h", $time, got);
      err_cnt++;
      return;
    end
    exp_r = result_q.pop_front();
    if (got.target !== exp_r.target)
      report_field("target", 24'(exp_r.target), 24'(got.target));
    if (got.addr !== exp_r.addr) report_field("bus_address", exp_r.addr, got.addr);
    if (got.wdata !== exp_r.wdata)
      report_field("bus_write_data", 24'(exp_r.wdata), 24'(got.wdata));
    if (got.rdata !== exp_r.rdata)
      report_field("read_data", 24'(exp_r.rdata), 24'(got.rdata));
    if (got.irq !== exp_r.irq) report_field("irq_out", 24'(exp_r.irq), 24'(got.irq));
    if (got.nmi !== exp_r.nmi) report_field("nmi_out", 24'(exp_r.nmi), 24'(got.nmi));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_result({m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[31:24],
                      m_axis_tdata[39:32], m_axis_tdata[40], m_axis_tdata[41]});
      end
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 97 == 0) rx_mode <= 2'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:     m_axis_tready <= 1'b1;
        RX_LIGHT:    m_axis_tready <= ($urandom_range(0, 3) != 0);
        RX_HEAVY:    m_axis_tready <= ($urandom_range(0, 3) == 0);
        RX_PERIODIC: m_axis_tready <= (rx_cycle[2:0] != 3'd0);
        default:     m_axis_tready <= 1'b1;
      endcase
    end
  end

  // ------------------------------------------------------------- stimulus
  // generator-side view: task register and which store entries hold data
  logic [7:0] gen_task = '0;
  bit         ram_seen [LOCAL_RAM_BYTES];
  bit         map_seen [MAP_BYTES];
  logic [9:0] ram_used [$];

  function automatic void queue_word(input logic [2:0] req, input logic [15:0] addr,
                                     input logic [7:0] data, input logic level);
    cpu_access_t w;
    w = '{req, addr, data, level};
    access_q.push_back(w);
    if (req == REQ_MEM_WR && gen_task[3:0] == 4'd0 && addr < LOC_TOP) begin
      if (addr < LOC_CTRL_BASE) begin
        if (!ram_seen[addr[9:0]]) ram_used.push_back(addr[9:0]);
        ram_seen[addr[9:0]] = 1'b1;
      end else if (addr == LOC_SW_TASK) begin
        gen_task = data;
      end else if (addr >= LOC_MAP_BASE && addr <= LOC_MAP_END) begin
        map_seen[addr[8:0]] = 1'b1;
      end
    end
  endfunction

  // memory access that never reads an unwritten RAM byte or map frame
  function automatic void queue_mem(input logic [2:0] req, input logic [15:0] addr,
                                    input logic [7:0] data);
    logic [8:0] idx;
    if (gen_task[3:0] == 4'd0 && addr < LOC_TOP) begin
      if (req == REQ_MEM_RD && addr > BOOT_END && addr < LOC_CTRL_BASE &&
          !ram_seen[addr[9:0]])
        queue_word(REQ_MEM_WR, addr, 8'($urandom), 1'b0);
      // leaving the local window is done once, on purpose, at the end
      if (req == REQ_MEM_WR && addr == LOC_SW_TASK) data[3:0] = 4'd0;
    end else if (!(req == REQ_MEM_RD && addr <= BOOT_END)) begin
      idx = {gen_task[3:0], addr[15:12], 1'b0};
      if (!map_seen[idx]) queue_word(REQ_MEM_WR, LOC_MAP_BASE + idx, 8'($urandom), 1'b0);
    end
    queue_word(req, addr, data, 1'($urandom));
  endfunction

  task automatic queue_random();
    int unsigned pick;
    int unsigned n;
    logic [15:0] a;
    pick = $urandom_range(0, 99);
    a = 16'($urandom);
    if (pick < 28) begin
      case ($urandom_range(0, 3))
        0: a = 16'($urandom_range(0, BOOT_END));
        1: a = a & 16'h0FFF;
        2: if (ram_used.size() != 0)
             a = 16'(ram_used[$urandom_range(0, ram_used.size() - 1)]);
        default: ;
      endcase
      queue_mem(REQ_MEM_RD, a, 8'($urandom));
    end else if (pick < 50) begin
      case ($urandom_range(0, 5))
        0: a = a & 16'h03FF;
        1: a = LOC_MAP_BASE | (a & 16'h01FF);
        2: a = LOC_MASK;
        3: a = LOC_SW_TASK;
        4: a = a & 16'h0FFF;
        default: ;
      endcase
      queue_mem(REQ_MEM_WR, a, 8'($urandom));
    end else if (pick < 64) begin
      queue_word(REQ_IO_RD, a, 8'($urandom), 1'($urandom));
    end else if (pick < 78) begin
      queue_word(REQ_IO_WR, a, 8'($urandom), 1'($urandom));
    end else if (pick < 88) begin
      queue_word(REQ_IRQ, a, 8'($urandom), 1'($urandom));
    end else if (pick < 91) begin
      queue_word(REQ_NMI, a, 8'($urandom), 1'($urandom));
    end else if (pick < 95) begin
      queue_word($urandom_range(0, 1) ? REQ_SPARE_6 : REQ_SPARE_7, a, 8'($urandom),
                 1'($urandom));
    end else begin
      // remap a few pages, pick a new upper task nibble, then translated traffic
      if (gen_task[3:0] == 4'd0) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_word(REQ_MEM_WR, LOC_MAP_BASE + {4'd0, 4'($urandom_range(1, 15)), 1'b0},
                              8'($urandom), 1'b0);
        queue_word(REQ_MEM_WR, LOC_SW_TASK, {4'($urandom), 4'd0}, 1'b0);
      end
      n = $urandom_range(4, 8);
      repeat (n) queue_mem($urandom_range(0, 1) ? REQ_MEM_RD : REQ_MEM_WR,
                           {4'($urandom_range(1, 15)), 12'($urandom)}, 8'($urandom));
    end
  endtask

  task automatic queue_directed();
    queue_word(REQ_MEM_RD, 16'h0000, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, BOOT_END, 8'hFF, 1'b1);
    queue_word(REQ_MEM_RD, LOC_SW_TASK, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, LOC_CTRL_BASE, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, LOC_MASK, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, 16'h0404, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, LOC_ROM_END, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, LOC_MAP_BASE, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, 16'h0C00, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, 16'h0FFF, 8'h00, 1'b0);
    queue_word(REQ_MEM_WR, 16'h03FF, 8'hFF, 1'b0);
    queue_word(REQ_MEM_RD, 16'h03FF, 8'h00, 1'b0);
    // interrupt enable in task 0 is mask bit 5
    queue_word(REQ_MEM_WR, LOC_MASK, 8'h20, 1'b0);
    queue_word(REQ_IRQ, 16'h0000, 8'h00, 1'b1);
    queue_word(REQ_MEM_RD, LOC_SW_TASK, 8'h00, 1'b0);
    queue_word(REQ_IRQ, 16'hFFFF, 8'hFF, 1'b0);
    // port echo into the upper byte
    queue_word(REQ_MEM_WR, LOC_MASK, 8'h80, 1'b0);
    queue_word(REQ_IO_RD, 16'hFFFF, 8'h00, 1'b0);
    queue_word(REQ_IO_WR, 16'h1234, 8'hFF, 1'b1);
    queue_word(REQ_MEM_WR, LOC_MAP_BASE + 16'h001E, 8'hFF, 1'b0);
    queue_word(REQ_MEM_RD, 16'hFFFF, 8'h00, 1'b0);
    queue_word(REQ_MEM_WR, LOC_MAP_BASE + 16'h0002, 8'h00, 1'b0);
    queue_word(REQ_MEM_WR, LOC_TOP, 8'h5A, 1'b0);
    // task write sets the trap flag, which moves the boot ROM window
    queue_word(REQ_MEM_WR, LOC_SW_TASK, 8'hF0, 1'b0);
    queue_word(REQ_MEM_RD, 16'h0000, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, LOC_SW_TASK, 8'h00, 1'b0);
    queue_word(REQ_MEM_RD, LOC_TOP, 8'h00, 1'b0);
    // nmi held off by the mask, then seen once an irq event recomputes
    queue_word(REQ_NMI, 16'h0000, 8'h00, 1'b0);
    queue_word(REQ_MEM_WR, LOC_MASK, 8'h20, 1'b0);
    queue_word(REQ_IRQ, 16'h0000, 8'h00, 1'b0);
    queue_word(REQ_SPARE_6, 16'($urandom), 8'($urandom), 1'b1);
    queue_word(REQ_SPARE_7, 16'($urandom), 8'($urandom), 1'b0);
  endtask

  task automatic queue_phase();
    queue_mem(REQ_MEM_RD, LOC_SW_TASK, 8'h00);
    repeat (PHASE_WORDS) queue_random();
  endtask

  task automatic drain();
    while (access_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_switches(input logic [7:0] v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    switch_byte = v;
  endtask

  // last phase: fill every frame of a task outside the local window, then enter it
  task automatic enter_far_task();
    logic [3:0] nib;
    int p;
    nib = 4'($urandom_range(1, 15));
    for (p = 0; p < 16; p++)
      queue_word(REQ_MEM_WR, LOC_MAP_BASE + {nib, 4'(p), 1'b0}, 8'($urandom), 1'b0);
    queue_word(REQ_MEM_WR, LOC_MASK, 8'($urandom), 1'b0);
    queue_word(REQ_MEM_WR, LOC_SW_TASK, {4'($urandom), nib}, 1'b0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_directed();
    queue_phase();
    drain();
    set_switches(8'h00);
    queue_phase();
    drain();
    set_switches(8'hFF);
    queue_phase();
    drain();
    set_switches(8'($urandom));
    queue_phase();
    drain();
    set_switches(8'($urandom));
    enter_far_task();
    queue_phase();
    drain();
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("task_paged_mmu_local_decode_tb: done, clean");
    end else begin
      $display("task_paged_mmu_local_decode_tb: done, errors");
    end
    $finish;
  end

endmodule
